>>> hdl/lmts_pkg.sv
// Shared types and timing constants for the LCD mode timing sequencer.
`timescale 1ns / 1ps

package lmts_pkg;

	// Dot timing of one frame.
	localparam int OAM_DOTS          = 80;
	localparam int TRANSFER_DOTS     = 172;
	localparam int HBLANK_DOTS       = 204;
	localparam int LAST_VISIBLE_LINE = 143;
	localparam int LINE_DOTS         = 456;
	localparam int VBLANK_DOTS       = 4560;

	// Widths of the counters and registers.
	localparam int DOT_CNT_W  = 13;
	localparam int LINE_CNT_W = 10;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_IRQ_ENABLE = 2'd1;

	// STAT enable bit positions.
	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_MATCH  = 3;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	// Control from the sequencer to the dot unit.
	typedef struct packed {
		logic       step;
		logic [7:0] line_compare;
		logic [3:0] stat_en;
	} dot_ctl_t;

	// Status from the dot unit back to the sequencer.
	typedef struct packed {
		mode_t      mode;
		logic [7:0] line;
		logic [7:0] pixel_x;
		logic       vblank_hit;
		logic       stat_hit;
	} dot_sts_t;

endpackage

>>> hdl/lmts_dot_unit.sv
// Single-dot step unit: holds the mode timing state and advances it one dot per step.
`timescale 1ns / 1ps

module lmts_dot_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  lmts_pkg::dot_ctl_t ctl,
	output lmts_pkg::dot_sts_t sts
);

	localparam logic [lmts_pkg::DOT_CNT_W-1:0] OAM_LIM =
		lmts_pkg::DOT_CNT_W'(lmts_pkg::OAM_DOTS);
	localparam logic [lmts_pkg::DOT_CNT_W-1:0] XFER_LIM =
		lmts_pkg::DOT_CNT_W'(lmts_pkg::TRANSFER_DOTS);
	localparam logic [lmts_pkg::DOT_CNT_W-1:0] HBLANK_LIM =
		lmts_pkg::DOT_CNT_W'(lmts_pkg::HBLANK_DOTS);
	localparam logic [lmts_pkg::DOT_CNT_W-1:0] VBLANK_LIM =
		lmts_pkg::DOT_CNT_W'(lmts_pkg::VBLANK_DOTS);
	localparam logic [lmts_pkg::LINE_CNT_W-1:0] LINE_LAST =
		lmts_pkg::LINE_CNT_W'(lmts_pkg::LINE_DOTS - 1);
	localparam logic [7:0] LAST_LINE = 8'(lmts_pkg::LAST_VISIBLE_LINE);

	lmts_pkg::mode_t                  mode_q, mode_n;
	logic [lmts_pkg::DOT_CNT_W-1:0]   cnt_q, cnt_n;
	logic [lmts_pkg::LINE_CNT_W-1:0]  sub_q, sub_n;
	logic [7:0]                       line_q, line_n, line_a;
	logic [7:0]                       x_q, x_n;
	logic                             chg;
	lmts_pkg::mode_t                  nxt;
	logic                             vb_hit, st_hit;

	// Next state for one dot. The sub counter tracks the dot counter modulo the line length.
	always_comb begin
		line_a = line_q;
		x_n    = x_q;
		chg    = 1'b0;
		nxt    = mode_q;
		vb_hit = 1'b0;
		st_hit = 1'b0;
		unique case (mode_q)
			lmts_pkg::MODE_OAM: begin
				if (cnt_q == OAM_LIM) begin
					chg = 1'b1;
					nxt = lmts_pkg::MODE_XFER;
				end
			end
			lmts_pkg::MODE_XFER: begin
				x_n = x_q + 8'd1;
				if (cnt_q == XFER_LIM) begin
					chg = 1'b1;
					nxt = lmts_pkg::MODE_HBLANK;
				end
			end
			lmts_pkg::MODE_HBLANK: begin
				if (cnt_q == HBLANK_LIM) begin
					chg = 1'b1;
					nxt = (line_q == LAST_LINE) ? lmts_pkg::MODE_VBLANK : lmts_pkg::MODE_OAM;
				end
			end
			lmts_pkg::MODE_VBLANK: begin
				if (sub_q == '0) begin
					line_a = line_q + 8'd1;
				end
				if (cnt_q == VBLANK_LIM) begin
					chg = 1'b1;
					nxt = lmts_pkg::MODE_OAM;
				end
			end
		endcase
		line_n = line_a;

		// Line match is checked after any VBlank line advance, before the mode change.
		if (line_a == ctl.line_compare && ctl.stat_en[lmts_pkg::EN_MATCH]) begin
			st_hit = 1'b1;
		end

		if (chg) begin
			unique case (nxt)
				lmts_pkg::MODE_OAM: begin
					x_n    = 8'd0;
					line_n = (mode_q == lmts_pkg::MODE_VBLANK) ? 8'd0 : line_a + 8'd1;
					st_hit = st_hit | ctl.stat_en[lmts_pkg::EN_OAM];
				end
				lmts_pkg::MODE_VBLANK: begin
					vb_hit = 1'b1;
					st_hit = st_hit | ctl.stat_en[lmts_pkg::EN_VBLANK];
				end
				lmts_pkg::MODE_HBLANK: begin
					st_hit = st_hit | ctl.stat_en[lmts_pkg::EN_HBLANK];
				end
				lmts_pkg::MODE_XFER: begin
				end
			endcase
			mode_n = nxt;
			cnt_n  = '0;
			sub_n  = '0;
		end else begin
			mode_n = mode_q;
			cnt_n  = cnt_q + lmts_pkg::DOT_CNT_W'(1);
			sub_n  = (sub_q == LINE_LAST) ? '0 : sub_q + lmts_pkg::LINE_CNT_W'(1);
		end
	end

	// Timing state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lmts_pkg::MODE_OAM;
			cnt_q  <= '0;
			sub_q  <= '0;
			line_q <= 8'd0;
			x_q    <= 8'd0;
		end else if (ctl.step) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
			sub_q  <= sub_n;
			line_q <= line_n;
			x_q    <= x_n;
		end
	end

	assign sts.mode       = mode_q;
	assign sts.line       = line_q;
	assign sts.pixel_x    = x_q;
	assign sts.vblank_hit = vb_hit;
	assign sts.stat_hit   = st_hit;

	// The state only moves on a step.
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.step |=> $stable(mode_q) && $stable(line_q) && $stable(x_q) && $stable(cnt_q))
		else $error("dot state changed without a step");

	// The OAM scan counter never runs past its limit.
	a_oam_limit: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lmts_pkg::MODE_OAM |-> cnt_q <= OAM_LIM)
		else $error("OAM scan counter past its limit");

	// Visible modes only ever see visible lines.
	a_visible_line: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == lmts_pkg::MODE_XFER || mode_q == lmts_pkg::MODE_HBLANK) |->
		line_q <= LAST_LINE)
		else $error("visible mode on a line past the last visible line");

	// The sub counter stays in step with the dot counter at mode entry.
	a_sub_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> sub_q == '0)
		else $error("line sub counter out of step with the dot counter");

endmodule

>>> hdl/lcd_mode_timing_sequencer_unit.sv
// Top level: stream handshake, configuration registers and the dot sequencer.
// An item is handled in order: one dot step per dot of its count, then a step that closes
// the run, then the output register loads once the output is free.
// The dot unit advances one dot per cycle while dots of a run remain.
// Input is not ready while an item runs or while its result waits to be taken.
// Reset (arst_n low, asynchronous): OAM scan at line 0, x 0, dot counter 0,
// both configuration registers 0, no result pending.
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lmts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lmts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata, // [3:0] dot_count, [7:4] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] vblank_irq, [1] stat_irq, [3:2] mode, [11:4] line, [19:12] pixel_x, [23:20] zero
	output logic [23:0]                       m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [lmts_pkg::COUNT_W-1:0]    remain_q;
	logic                            vb_acc_q, st_acc_q;
	logic [7:0]                      line_compare_q;
	logic [3:0]                      stat_en_q;
	logic                            out_free;
	lmts_pkg::dot_ctl_t              ctl;
	lmts_pkg::dot_sts_t              sts;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_compare_q <= 8'd0;
			stat_en_q      <= 4'd0;
		end else if (cfg_we) begin
			if (cfg_index == lmts_pkg::REG_LINE_COMPARE) begin
				line_compare_q <= cfg_data;
			end else if (cfg_index == lmts_pkg::REG_STAT_IRQ_ENABLE) begin
				stat_en_q <= cfg_data[3:0];
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	assign ctl.step         = (state_q == ST_RUN) && (remain_q != '0);
	assign ctl.line_compare = line_compare_q;
	assign ctl.stat_en      = stat_en_q;

	lmts_dot_unit u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	// Sequencer: count down the dots, then load the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			remain_q <= '0;
			vb_acc_q <= 1'b0;
			st_acc_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			// A taken result clears the output unless the next one loads in this cycle.
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						remain_q <= s_tdata[lmts_pkg::COUNT_W-1:0];
						vb_acc_q <= 1'b0;
						st_acc_q <= 1'b0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (remain_q != '0) begin
						remain_q <= remain_q - lmts_pkg::COUNT_W'(1);
						vb_acc_q <= vb_acc_q | sts.vblank_hit;
						st_acc_q <= st_acc_q | sts.stat_hit;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {4'd0, sts.pixel_x, sts.line, sts.mode, st_acc_q, vb_acc_q};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result only appears at the end of a run.
	a_result_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the end of a run");

	// An accepted item always starts a run.
	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_RUN)
		else $error("accepted item did not start a run");

	// The dot unit steps only while dots remain.
	a_step_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |=> remain_q == $past(remain_q) - lmts_pkg::COUNT_W'(1))
		else $error("dot step without a count down");

endmodule
